@@ src/tec_pkg.sv @@
`default_nettype none
package tec_pkg;

    localparam int FRAC_BITS = 4;
    localparam int COORD_W   = 16;
    localparam int PIX_W     = 11;
    localparam int DIM_W     = 12;
    localparam int OFFSET_W  = 24;
    localparam int BASE_W    = PIX_W + DIM_W;
    localparam int CENTER_W  = PIX_W + FRAC_BITS;
    localparam int DELTA_W   = COORD_W + 1;
    localparam int REL_W     = CENTER_W + 3;
    localparam int PROD_W    = DELTA_W + REL_W;
    localparam int EDGE_W    = PROD_W + 1;
    localparam int BOX_W     = COORD_W - FRAC_BITS + 1;

    localparam logic [DIM_W-1:0] MAX_SCREEN_DIM = DIM_W'(2048);
    localparam logic [DIM_W-1:0] WIDTH_RESET    = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET   = DIM_W'(480);
    localparam logic [COORD_W:0] CEIL_BIAS      = (COORD_W+1)'((1 << FRAC_BITS) - 1);
    localparam logic [CENTER_W-1:0] HALF_PIXEL  = CENTER_W'(1 << (FRAC_BITS - 1));

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [REL_W-1:0]   relx;
        logic signed [REL_W-1:0]   rely;
    } edge_setup_t;

    typedef struct packed {
        edge_setup_t [2:0]       edg;
        logic signed [BOX_W-1:0] left;
        logic signed [BOX_W-1:0] right;
        logic signed [BOX_W-1:0] bottom;
        logic signed [BOX_W-1:0] top;
        logic [PIX_W-1:0]        px;
        logic [PIX_W-1:0]        py;
        logic                    on_screen;
        logic [BASE_W-1:0]       row_base;
    } setup_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] pa;
        logic signed [PROD_W-1:0] pb;
    } edge_prod_t;

    typedef struct packed {
        edge_prod_t [2:0]    prod;
        logic                in_box;
        logic                on_screen;
        logic [OFFSET_W-1:0] offset;
    } prod_t;

endpackage
`default_nettype wire

@@ src/tec_setup.sv @@
`default_nettype none
module tec_setup
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire logic                                in_ok,
    input  wire logic signed [tec_pkg::COORD_W-1:0]  ax,
    input  wire logic signed [tec_pkg::COORD_W-1:0]  ay,
    input  wire logic signed [tec_pkg::COORD_W-1:0]  bx,
    input  wire logic signed [tec_pkg::COORD_W-1:0]  by,
    input  wire logic signed [tec_pkg::COORD_W-1:0]  cx,
    input  wire logic signed [tec_pkg::COORD_W-1:0]  cy,
    input  wire logic [tec_pkg::PIX_W-1:0]           px,
    input  wire logic [tec_pkg::PIX_W-1:0]           py,
    input  wire logic [tec_pkg::DIM_W-1:0]           width,
    input  wire logic [tec_pkg::DIM_W-1:0]           height,
    output logic                                     valid_reg,
    output tec_pkg::setup_t                          data_reg
);

    tec_pkg::setup_t data_next;
    logic signed [tec_pkg::COORD_W-1:0] min_x, max_x, min_y, max_y;
    logic signed [tec_pkg::COORD_W:0]   ceil_x, ceil_y;
    logic [tec_pkg::CENTER_W-1:0]       cen_x, cen_y;
    logic signed [tec_pkg::REL_W-1:0]   sx, sy;

    function automatic logic signed [tec_pkg::DELTA_W-1:0] delta
    (
        input logic signed [tec_pkg::COORD_W-1:0] p1,
        input logic signed [tec_pkg::COORD_W-1:0] p0
    );
        return {p1[tec_pkg::COORD_W-1], p1} - {p0[tec_pkg::COORD_W-1], p0};
    endfunction

    function automatic logic signed [tec_pkg::REL_W-1:0] rel
    (
        input logic signed [tec_pkg::REL_W-1:0]   s,
        input logic signed [tec_pkg::COORD_W-1:0] p
    );
        return s - tec_pkg::REL_W'(p);
    endfunction

    always_comb
    begin
        min_x = (ax < bx) ? ax : bx;
        min_x = (min_x < cx) ? min_x : cx;
        max_x = (ax > bx) ? ax : bx;
        max_x = (max_x > cx) ? max_x : cx;
        min_y = (ay < by) ? ay : by;
        min_y = (min_y < cy) ? min_y : cy;
        max_y = (ay > by) ? ay : by;
        max_y = (max_y > cy) ? max_y : cy;
        ceil_x = {max_x[tec_pkg::COORD_W-1], max_x} + tec_pkg::CEIL_BIAS;
        ceil_y = {max_y[tec_pkg::COORD_W-1], max_y} + tec_pkg::CEIL_BIAS;

        cen_x = {px, tec_pkg::FRAC_BITS'(0)} + tec_pkg::HALF_PIXEL;
        cen_y = {py, tec_pkg::FRAC_BITS'(0)} + tec_pkg::HALF_PIXEL;
        sx = $signed({3'b000, cen_x});
        sy = $signed({3'b000, cen_y});

        data_next.edg[0].dx   = delta(bx, ax);
        data_next.edg[0].dy   = delta(by, ay);
        data_next.edg[0].relx = rel(sx, ax);
        data_next.edg[0].rely = rel(sy, ay);
        data_next.edg[1].dx   = delta(cx, bx);
        data_next.edg[1].dy   = delta(cy, by);
        data_next.edg[1].relx = rel(sx, bx);
        data_next.edg[1].rely = rel(sy, by);
        data_next.edg[2].dx   = delta(ax, cx);
        data_next.edg[2].dy   = delta(ay, cy);
        data_next.edg[2].relx = rel(sx, cx);
        data_next.edg[2].rely = rel(sy, cy);

        data_next.left   = {min_x[tec_pkg::COORD_W-1],
                            min_x[tec_pkg::COORD_W-1:tec_pkg::FRAC_BITS]};
        data_next.right  = ceil_x[tec_pkg::COORD_W:tec_pkg::FRAC_BITS];
        data_next.bottom = {min_y[tec_pkg::COORD_W-1],
                            min_y[tec_pkg::COORD_W-1:tec_pkg::FRAC_BITS]};
        data_next.top    = ceil_y[tec_pkg::COORD_W:tec_pkg::FRAC_BITS];

        data_next.px        = px;
        data_next.py        = py;
        data_next.on_screen = ({1'b0, px} < width) && ({1'b0, py} < height);
        data_next.row_base  = tec_pkg::BASE_W'(py) * tec_pkg::BASE_W'(width);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_ok)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

@@ src/tec_edge.sv @@
`default_nettype none
module tec_edge
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            in_valid,
    input  tec_pkg::setup_t      in_data,
    output logic                 valid_reg,
    output tec_pkg::prod_t       data_reg
);

    tec_pkg::prod_t data_next;
    logic signed [tec_pkg::BOX_W-1:0] sx, sy;
    logic [tec_pkg::OFFSET_W-1:0]     base;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            data_next.prod[i].pa = in_data.edg[i].dy * in_data.edg[i].relx;
            data_next.prod[i].pb = in_data.edg[i].dx * in_data.edg[i].rely;
        end
        sx = $signed({2'b00, in_data.px});
        sy = $signed({2'b00, in_data.py});
        data_next.in_box = (sx >= in_data.left) && (sx < in_data.right)
                        && (sy >= in_data.bottom) && (sy < in_data.top);
        data_next.on_screen = in_data.on_screen;
        base = tec_pkg::OFFSET_W'(in_data.row_base) + tec_pkg::OFFSET_W'(in_data.px);
        data_next.offset = {base[tec_pkg::OFFSET_W-2:0], 1'b0} + base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

@@ src/tec_resolve.sv @@
`default_nettype none
module tec_resolve
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  tec_pkg::prod_t                     in_data,
    output logic                               valid_reg,
    output logic                               covered_reg,
    output logic [tec_pkg::OFFSET_W-1:0]       offset_reg
);

    logic signed [tec_pkg::EDGE_W-1:0] e [3];
    logic [2:0]                        pass;
    logic                              covered_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e[i] = {in_data.prod[i].pa[tec_pkg::PROD_W-1], in_data.prod[i].pa}
                 - {in_data.prod[i].pb[tec_pkg::PROD_W-1], in_data.prod[i].pb};
            pass[i] = e[i][tec_pkg::EDGE_W-1] || (e[i] == '0);
        end
        covered_next = (&pass) && in_data.in_box && in_data.on_screen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            covered_reg <= covered_next;
            offset_reg  <= covered_next ? in_data.offset : '0;
        end
    end

endmodule
`default_nettype wire

@@ src/triangle_edge_coverage_test.sv @@
`default_nettype none
// Tests one pixel centre per request against a triangle given by three signed Q12.4
// vertices: bounding box, an edge function per triangle edge (a single winding only) and the screen size
// set through the configuration port (widths above 2048 act as 2048). One request can
// enter every cycle while in_stall is low; each result passes through the setup,
// multiply and edge-sign register stages. Bubbles in the pipe are squeezed out
// while the output is stalled, so in_stall only rises when all three stages are full.
// pixel_offset is (row*width+col)*3 modulo 2^24 for a covered pixel and zero otherwise.
module triangle_edge_coverage_test
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic                                cfg_index,
    input  wire logic [tec_pkg::DIM_W-1:0]           cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [tec_pkg::COORD_W-1:0]  vert_a_x,
    input  wire logic signed [tec_pkg::COORD_W-1:0]  vert_a_y,
    input  wire logic signed [tec_pkg::COORD_W-1:0]  vert_b_x,
    input  wire logic signed [tec_pkg::COORD_W-1:0]  vert_b_y,
    input  wire logic signed [tec_pkg::COORD_W-1:0]  vert_c_x,
    input  wire logic signed [tec_pkg::COORD_W-1:0]  vert_c_y,
    input  wire logic [tec_pkg::PIX_W-1:0]           sample_x,
    input  wire logic [tec_pkg::PIX_W-1:0]           sample_y,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     covered,
    output logic [tec_pkg::OFFSET_W-1:0]             pixel_offset
);

    logic [tec_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [tec_pkg::DIM_W-1:0] width, height;
    logic                      adv1, adv2, adv3;
    logic                      s1_valid, s2_valid;
    tec_pkg::setup_t           s1_data;
    tec_pkg::prod_t            s2_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= tec_pkg::WIDTH_RESET;
            height_reg <= tec_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tec_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                tec_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign width  = (width_reg > tec_pkg::MAX_SCREEN_DIM) ? tec_pkg::MAX_SCREEN_DIM : width_reg;
    assign height = (height_reg > tec_pkg::MAX_SCREEN_DIM) ? tec_pkg::MAX_SCREEN_DIM : height_reg;

    assign adv3     = !out_valid || !out_stall;
    assign adv2     = !s2_valid || adv3;
    assign adv1     = !s1_valid || adv2;
    assign in_stall = !adv1;

    tec_setup u_setup
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv1),
        .in_ok     (in_valid),
        .ax        (vert_a_x),
        .ay        (vert_a_y),
        .bx        (vert_b_x),
        .by        (vert_b_y),
        .cx        (vert_c_x),
        .cy        (vert_c_y),
        .px        (sample_x),
        .py        (sample_y),
        .width     (width),
        .height    (height),
        .valid_reg (s1_valid),
        .data_reg  (s1_data)
    );

    tec_edge u_edge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv2),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .valid_reg (s2_valid),
        .data_reg  (s2_data)
    );

    tec_resolve u_resolve
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv3),
        .in_valid    (s2_valid),
        .in_data     (s2_data),
        .valid_reg   (out_valid),
        .covered_reg (covered),
        .offset_reg  (pixel_offset)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid && s2_valid && out_valid && out_stall))
        else $error("input stalled with room in the pipeline");

    a_offset_zero_uncovered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !covered) |-> (pixel_offset == '0))
        else $error("nonzero offset on uncovered pixel");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid && !adv2) |=> s2_valid)
        else $error("held request dropped from multiply stage");
`endif

endmodule
`default_nettype wire
